// File: design/assert_macros.svh
// Concurrent assertion helpers, clocked on clk, quiet during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: design/trtl_pkg.sv
`default_nettype none
package trtl_pkg;

  localparam int TableDepth    = 16;
  localparam int NumInterfaces = 16;
  localparam logic [31:0] LfsrTaps = 32'h8020_0003;

  typedef enum logic [2:0] {
    CMD_LOOKUP  = 3'd0,
    CMD_ADD_HST = 3'd1,
    CMD_ADD_NET = 3'd2,
    CMD_ADD_EXT = 3'd3,
    CMD_REMOVE  = 3'd4
  } trtl_cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NORTE = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } trtl_status_e;

  typedef enum logic [1:0] {
    TIER_HST = 2'd0,
    TIER_NET = 2'd1,
    TIER_EXT = 2'd2
  } trtl_tier_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_EXEC = 3'd1,
    S_HIT  = 3'd2,
    S_MOD  = 3'd3,
    S_SEL  = 3'd4,
    S_DONE = 3'd5
  } trtl_state_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] addr;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [3:0]  interface_req;
    logic [4:0]  oif_filter;
    logic [5:0]  entry_index;
  } trtl_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] route_dest;
    logic [31:0] route_gateway;
    logic [3:0]  route_interface;
    logic [5:0]  route_count;
  } trtl_out_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] mask;
    logic [31:0] gw;
    logic [3:0]  ifc;
  } trtl_entry_t;

  typedef struct packed {
    logic add;
    logic rem;
  } trtl_tctl_t;

endpackage
`default_nettype wire

// File: design/tiered_route_table_lookup.sv
// Add, remove and unknown commands: S_EXEC, then S_DONE, which registers the result.
// Lookup: S_EXEC, S_HIT, then S_SEL scans table entries up to the chosen candidate
// (at most TABLE_DEPTH); with random pick on, S_MOD first runs the bit-serial LFSR
// modulo. One item at a time; the entry scan, the modulo and a stalled output set
// the rate. Synchronous active-low reset empties all three tables, sets the LFSR
// to one and clears random pick; entry contents are not reset.
`default_nettype none
`include "assert_macros.svh"
module tiered_route_table_lookup import trtl_pkg::*; #(
  parameter int TABLE_DEPTH = TableDepth
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire trtl_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output trtl_out_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic      cfg_wdata
);

  localparam int IDXW = $clog2(TABLE_DEPTH);
  localparam int CNTW = $clog2(TABLE_DEPTH + 1);
  localparam int SW   = (CNTW + 2 > 6) ? CNTW + 2 : 6;

  trtl_state_e state_r, state_nxt;
  trtl_in_t    item_r;
  logic        random_r;
  logic [31:0] lfsr_r, lfsr_step;
  logic        out_valid_r;
  trtl_out_t   out_r, res_r;
  trtl_out_t   res_nxt, out_nxt;

  logic [TABLE_DEPTH-1:0] hh_r, nh_r, eh_r, cand_r;
  logic [TABLE_DEPTH-1:0] hh, nh, eh;
  logic [CNTW-1:0] hn, nn, en, want_r, seen_r;
  logic [CNTW-1:0] hc, nc, pick_cnt;
  logic [IDXW-1:0] k_r;
  trtl_tier_e      tier_r;

  trtl_tctl_t  hctl, nctl, ectl;
  logic [IDXW-1:0] rem_idx;
  trtl_entry_t new_e, he, ne, ee, sel_e;

  logic            mod_start, mod_done;
  logic [CNTW-1:0] mod_rem;

  logic [SW-1:0] idx_w, off_n, off_e;
  logic          hfull, nfull, efull;
  logic          found;

  assign new_e = '{addr: item_r.addr, mask: item_r.mask,
                   gw: item_r.gateway, ifc: item_r.interface_req};

  trtl_tier #(.TABLE_DEPTH(TABLE_DEPTH), .EXACT(1'b1)) u_hst (
    .clk(clk), .rst_n(rst_n), .ctl(hctl), .rem_idx(rem_idx), .new_e(new_e),
    .dst(item_r.addr), .filt(item_r.oif_filter), .rd_idx(k_r),
    .count(hn), .hits(hh), .rd_e(he)
  );
  trtl_tier #(.TABLE_DEPTH(TABLE_DEPTH), .EXACT(1'b0)) u_net (
    .clk(clk), .rst_n(rst_n), .ctl(nctl), .rem_idx(rem_idx), .new_e(new_e),
    .dst(item_r.addr), .filt(item_r.oif_filter), .rd_idx(k_r),
    .count(nn), .hits(nh), .rd_e(ne)
  );
  trtl_tier #(.TABLE_DEPTH(TABLE_DEPTH), .EXACT(1'b0)) u_ext (
    .clk(clk), .rst_n(rst_n), .ctl(ectl), .rem_idx(rem_idx), .new_e(new_e),
    .dst(item_r.addr), .filt(item_r.oif_filter), .rd_idx(k_r),
    .count(en), .hits(eh), .rd_e(ee)
  );

  trtl_mod #(.DW(CNTW)) u_mod (
    .clk(clk), .rst_n(rst_n), .start(mod_start), .num(lfsr_step),
    .den(pick_cnt), .done(mod_done), .rem(mod_rem)
  );

  assign lfsr_step = (lfsr_r >> 1) ^ (lfsr_r[0] ? LfsrTaps : 32'd0);
  assign hc = CNTW'($countones(hh_r));
  assign nc = CNTW'($countones(nh_r));
  assign pick_cnt = (hc != '0) ? hc : ((nc != '0) ? nc : CNTW'(1));

  assign idx_w = SW'(item_r.entry_index);
  assign off_n = idx_w - SW'(hn);
  assign off_e = off_n - SW'(nn);
  assign hfull = (hn == CNTW'(TABLE_DEPTH));
  assign nfull = (nn == CNTW'(TABLE_DEPTH));
  assign efull = (en == CNTW'(TABLE_DEPTH));
  assign found = cand_r[k_r] && (seen_r == want_r);

  always_comb begin
    case (tier_r)
      TIER_HST: sel_e = he;
      TIER_NET: sel_e = ne;
      default:  sel_e = ee;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: begin
        if (item_r.command == CMD_LOOKUP) state_nxt = S_HIT;
        else state_nxt = S_DONE;
      end
      S_HIT: begin
        if (hc == '0 && nc == '0 && eh_r == '0) state_nxt = S_DONE;
        else if (random_r) state_nxt = S_MOD;
        else state_nxt = S_SEL;
      end
      S_MOD: if (mod_done) state_nxt = S_SEL;
      S_SEL: if (found) state_nxt = S_DONE;
      S_DONE: if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == S_IDLE);
    hctl      = '0;
    nctl      = '0;
    ectl      = '0;
    rem_idx   = '0;
    mod_start = (state_r == S_HIT) && random_r &&
                !(hc == '0 && nc == '0 && eh_r == '0);
    if (state_r == S_EXEC) begin
      case (item_r.command)
        CMD_ADD_HST: hctl.add = !hfull;
        CMD_ADD_NET: nctl.add = !nfull;
        CMD_ADD_EXT: ectl.add = !efull;
        CMD_REMOVE: begin
          if (idx_w < SW'(hn)) begin
            hctl.rem = 1'b1;
            rem_idx  = idx_w[IDXW-1:0];
          end else if (off_n < SW'(nn)) begin
            nctl.rem = 1'b1;
            rem_idx  = off_n[IDXW-1:0];
          end else if (off_e < SW'(en)) begin
            ectl.rem = 1'b1;
            rem_idx  = off_e[IDXW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_nxt = res_r;
    case (state_r)
      S_EXEC: begin
        res_nxt = '0;
        case (item_r.command)
          CMD_ADD_HST: res_nxt.status = hfull ? ST_FULL : ST_OK;
          CMD_ADD_NET: res_nxt.status = nfull ? ST_FULL : ST_OK;
          CMD_ADD_EXT: res_nxt.status = efull ? ST_FULL : ST_OK;
          CMD_REMOVE: begin
            if (!(idx_w < SW'(hn)) && !(off_n < SW'(nn)) && !(off_e < SW'(en))) begin
              res_nxt.status = ST_RANGE;
            end
          end
          default: ;
        endcase
      end
      S_HIT: begin
        if (hc == '0 && nc == '0 && eh_r == '0) begin
          res_nxt.status = ST_NORTE;
        end
      end
      S_SEL: begin
        if (found) begin
          res_nxt.status          = ST_OK;
          res_nxt.route_dest      = sel_e.addr;
          res_nxt.route_gateway   = sel_e.gw;
          res_nxt.route_interface = sel_e.ifc;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_nxt             = res_r;
    out_nxt.route_count = 6'(SW'(hn) + SW'(nn) + SW'(en));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      random_r    <= 1'b0;
      lfsr_r      <= 32'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        random_r <= cfg_wdata;
      end
      if (mod_start) begin
        lfsr_r <= lfsr_step;
      end
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      item_r <= in_data;
    end
    res_r <= res_nxt;
    case (state_r)
      S_EXEC: begin
        hh_r <= hh;
        nh_r <= nh;
        eh_r <= eh;
      end
      S_HIT: begin
        k_r    <= '0;
        seen_r <= '0;
        want_r <= '0;
        if (hc != '0) begin
          tier_r <= TIER_HST;
          cand_r <= hh_r;
        end else if (nc != '0) begin
          tier_r <= TIER_NET;
          cand_r <= nh_r;
        end else begin
          tier_r <= TIER_EXT;
          cand_r <= eh_r;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          want_r <= mod_rem;
        end
      end
      S_SEL: begin
        k_r <= k_r + IDXW'(1);
        if (cand_r[k_r]) begin
          seen_r <= seen_r + CNTW'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_r <= out_nxt;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ASSERT_CLK(a_sel_has_cand, (state_r == S_SEL) |-> (cand_r != '0), "scan with no candidate")
  `ASSERT_CLK(a_accept_exec, (in_valid && in_ready) |=> (state_r == S_EXEC), "accept lost")
  `ASSERT_NEVER(a_one_op, $countones({hctl, nctl, ectl}) > 1, "two table updates at once")

endmodule
`default_nettype wire

// File: design/trtl_cell.sv
`default_nettype none
module trtl_cell import trtl_pkg::*; #(
  parameter bit EXACT = 1'b0
) (
  input  wire logic        clk,
  input  wire logic        load,
  input  wire logic        shift,
  input  wire trtl_entry_t new_e,
  input  wire trtl_entry_t nb_e,
  input  wire logic [31:0] dst,
  input  wire logic [4:0]  filt,
  output trtl_entry_t      ent,
  output logic             hit
);

  trtl_entry_t ent_r, ent_nxt;
  logic        match;

  always_comb begin
    ent_nxt = ent_r;
    if (load) begin
      ent_nxt = new_e;
    end else if (shift) begin
      ent_nxt = nb_e;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  always_comb begin
    if (EXACT) begin
      match = (ent_r.addr == dst);
    end else begin
      match = ((dst & ent_r.mask) == (ent_r.addr & ent_r.mask));
    end
    hit = match;
    if ((32'(filt) < 32'(NumInterfaces)) && (ent_r.ifc != filt[3:0])) begin
      hit = 1'b0;
    end
  end

  assign ent = ent_r;

endmodule
`default_nettype wire

// File: design/trtl_tier.sv
`default_nettype none
module trtl_tier import trtl_pkg::*; #(
  parameter int TABLE_DEPTH = TableDepth,
  parameter bit EXACT       = 1'b0,
  localparam int IDXW = $clog2(TABLE_DEPTH),
  localparam int CNTW = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire trtl_tctl_t             ctl,
  input  wire logic [IDXW-1:0]        rem_idx,
  input  wire trtl_entry_t            new_e,
  input  wire logic [31:0]            dst,
  input  wire logic [4:0]             filt,
  input  wire logic [IDXW-1:0]        rd_idx,
  output logic [CNTW-1:0]             count,
  output logic [TABLE_DEPTH-1:0]      hits,
  output trtl_entry_t                 rd_e
);

  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  trtl_entry_t      ents [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] raw;

  for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_cell
    trtl_entry_t nb;
    logic        ld, sh;
    if (j == TABLE_DEPTH - 1) begin : g_last
      assign nb = ents[j];
      assign sh = 1'b0;
    end else begin : g_mid
      assign nb = ents[j+1];
      assign sh = ctl.rem && (IDXW'(j) >= rem_idx);
    end
    assign ld = ctl.add && (cnt_r == CNTW'(j));
    trtl_cell #(.EXACT(EXACT)) u_cell (
      .clk   (clk),
      .load  (ld),
      .shift (sh),
      .new_e (new_e),
      .nb_e  (nb),
      .dst   (dst),
      .filt  (filt),
      .ent   (ents[j]),
      .hit   (raw[j])
    );
    assign hits[j] = raw[j] && (CNTW'(j) < cnt_r);
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.add) begin
      cnt_nxt = cnt_r + CNTW'(1);
    end else if (ctl.rem) begin
      cnt_nxt = cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign count = cnt_r;
  assign rd_e  = ents[rd_idx];

endmodule
`default_nettype wire

// File: design/trtl_mod.sv
`default_nettype none
`include "assert_macros.svh"
module trtl_mod import trtl_pkg::*; #(
  parameter int DW = 5
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [31:0]   num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [DW-1:0]      rem
);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [5:0]    step_r, step_nxt;
  logic [31:0]   num_r, num_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, num_r[31]};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = 6'd32;
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        trial = trial - {1'b0, den_r};
      end
      rem_nxt  = trial[DW-1:0];
      num_nxt  = {num_r[30:0], 1'b0};
      step_nxt = step_r - 6'd1;
      if (step_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

  `ASSERT_CLK(a_rem_below_den, done_r |-> (rem_r < den_r), "remainder not below divisor")
  `ASSERT_CLK(a_done_after_busy, done_r |-> $past(busy_r), "done without busy")

endmodule
`default_nettype wire

// File: verif/tb_top.sv
module tb_top;
  import trtl_pkg::*;

  typedef struct {
    trtl_in_t   item;
    logic       check_fixed;
    trtl_out_t  fixed;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  trtl_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  trtl_out_t out_data;
  logic      cfg_we;
  logic      cfg_wdata;

  tiered_route_table_lookup i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [31:0] tbl_addr [3][TableDepth];
  logic [31:0] tbl_mask [3][TableDepth];
  logic [31:0] tbl_gw   [3][TableDepth];
  logic [3:0]  tbl_if   [3][TableDepth];
  int          tbl_n    [3];
  logic [31:0] pick_lfsr;
  logic        ecmp_mode;

  trtl_out_t   route_q[$];
  stim_row_t   rows[$];
  int          errors;
  int          cycles;
  int          results_seen;
  logic        hold_off;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic logic entry_match(input int t, input int k, input logic [31:0] dst,
                                       input logic [4:0] filt);
    logic hit;
    if (t == TIER_HST) hit = (tbl_addr[t][k] == dst);
    else hit = ((dst & tbl_mask[t][k]) == (tbl_addr[t][k] & tbl_mask[t][k]));
    if (hit && filt < NumInterfaces && tbl_if[t][k] != filt[3:0]) hit = 1'b0;
    return hit;
  endfunction

  function automatic trtl_out_t route_predict(input trtl_in_t it);
    trtl_out_t r;
    int t;
    int c;
    int want;
    int idx;
    int j;
    r = '0;
    r.status = ST_OK;
    case (it.command)
      CMD_LOOKUP: begin
        c = 0;
        for (t = 0; t < 3; t++) begin
          c = 0;
          for (j = 0; j < tbl_n[t]; j++) begin
            if (entry_match(t, j, it.addr, it.oif_filter)) begin
              c++;
              if (t == TIER_EXT) break;
            end
          end
          if (c != 0) break;
        end
        if (c == 0) begin
          r.status = ST_NORTE;
        end else begin
          want = 0;
          if (ecmp_mode) begin
            pick_lfsr = pick_lfsr[0] ? ((pick_lfsr >> 1) ^ LfsrTaps) : (pick_lfsr >> 1);
            want = pick_lfsr % c;
          end
          for (j = 0; j < tbl_n[t]; j++) begin
            if (entry_match(t, j, it.addr, it.oif_filter)) begin
              if (want == 0) break;
              want--;
            end
          end
          r.route_dest = tbl_addr[t][j];
          r.route_gateway = tbl_gw[t][j];
          r.route_interface = tbl_if[t][j];
        end
      end
      CMD_ADD_HST, CMD_ADD_NET, CMD_ADD_EXT: begin
        t = int'(it.command) - 1;
        if (tbl_n[t] >= TableDepth) begin
          r.status = ST_FULL;
        end else begin
          tbl_addr[t][tbl_n[t]] = it.addr;
          tbl_mask[t][tbl_n[t]] = (t == TIER_HST) ? 32'd0 : it.mask;
          tbl_gw[t][tbl_n[t]] = it.gateway;
          tbl_if[t][tbl_n[t]] = it.interface_req;
          tbl_n[t]++;
        end
      end
      CMD_REMOVE: begin
        idx = it.entry_index;
        r.status = ST_RANGE;
        for (t = 0; t < 3; t++) begin
          if (idx < tbl_n[t]) begin
            for (j = idx; j + 1 < tbl_n[t]; j++) begin
              tbl_addr[t][j] = tbl_addr[t][j + 1];
              tbl_mask[t][j] = tbl_mask[t][j + 1];
              tbl_gw[t][j] = tbl_gw[t][j + 1];
              tbl_if[t][j] = tbl_if[t][j + 1];
            end
            tbl_n[t]--;
            r.status = ST_OK;
            break;
          end
          idx -= tbl_n[t];
        end
      end
      default: ;
    endcase
    r.route_count = 6'(tbl_n[0] + tbl_n[1] + tbl_n[2]);
    return r;
  endfunction

  function automatic trtl_in_t mk(input trtl_cmd_e cmd, input logic [31:0] a,
                                  input logic [31:0] m, input logic [31:0] g,
                                  input logic [3:0] ifc, input logic [4:0] filt,
                                  input logic [5:0] idx);
    trtl_in_t it;
    it.command = cmd;
    it.addr = a;
    it.mask = m;
    it.gateway = g;
    it.interface_req = ifc;
    it.oif_filter = filt;
    it.entry_index = idx;
    return it;
  endfunction

  function automatic trtl_out_t res(input trtl_status_e st, input logic [5:0] cnt);
    trtl_out_t r;
    r = '0;
    r.status = st;
    r.route_count = cnt;
    return r;
  endfunction

  task automatic add_row(input trtl_in_t it, input logic chk, input trtl_out_t want);
    stim_row_t row;
    row.item = it;
    row.check_fixed = chk;
    row.fixed = want;
    rows = {rows, row};
  endtask

  task automatic send_item(input trtl_in_t it);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    route_q = {route_q, route_predict(it)};
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (route_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_ecmp(input logic v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    ecmp_mode = v;
  endtask

  function automatic logic [31:0] pick_addr;
    case ($urandom_range(0, 3))
      0: return 32'h0A00_0000 | $urandom_range(0, 7);
      1: return 32'h0A00_0000 | ($urandom_range(0, 3) << 8) | $urandom_range(0, 7);
      2: return 32'hC0A8_0000 | $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_mask;
    case ($urandom_range(0, 4))
      0: return 32'hFFFF_FF00;
      1: return 32'hFFFF_0000;
      2: return 32'hFF00_0000;
      3: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic trtl_in_t rand_item;
    trtl_in_t it;
    int total;
    int sel;
    it = mk(CMD_LOOKUP, pick_addr(), pick_mask(), $urandom, 4'($urandom),
            5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
    if ($urandom_range(0, 1)) it.oif_filter = 5'($urandom_range(0, 3));
    if ($urandom_range(0, 3) == 0) it.interface_req = 4'($urandom_range(0, 3));
    total = tbl_n[0] + tbl_n[1] + tbl_n[2];
    sel = $urandom_range(0, 99);
    if (sel < 40) it.command = CMD_LOOKUP;
    else if (sel < 55) it.command = CMD_ADD_HST;
    else if (sel < 70) it.command = CMD_ADD_NET;
    else if (sel < 80) it.command = CMD_ADD_EXT;
    else if (sel < 97) begin
      it.command = CMD_REMOVE;
      if (total > 0 && $urandom_range(0, 3) != 0) it.entry_index = 6'($urandom_range(0, total - 1));
    end else it.command = trtl_cmd_e'(3'($urandom_range(5, 7)));
    if (total > 36 && it.command inside {CMD_ADD_HST, CMD_ADD_NET, CMD_ADD_EXT}
        && $urandom_range(0, 1)) begin
      it.command = CMD_REMOVE;
      it.entry_index = 6'($urandom_range(0, total - 1));
    end
    return it;
  endfunction

  // result side
  always @(posedge clk) begin
    trtl_out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (route_q.size() == 0) begin
        report("unexpected item", 32'd0, 32'd0);
      end else begin
        want = route_q.pop_front();
        if (out_data.status != want.status) report("status", out_data.status, want.status);
        if (out_data.route_dest != want.route_dest)
          report("route_dest", out_data.route_dest, want.route_dest);
        if (out_data.route_gateway != want.route_gateway)
          report("route_gateway", out_data.route_gateway, want.route_gateway);
        if (out_data.route_interface != want.route_interface)
          report("route_interface", out_data.route_interface, want.route_interface);
        if (out_data.route_count != want.route_count)
          report("route_count", out_data.route_count, want.route_count);
      end
    end
  end

  initial begin
    int wait_left;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end else if (wait_left > 0) begin
        out_ready <= 1'b0;
        wait_left--;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
        if (out_valid && out_ready) wait_left = $urandom_range(0, 3);
      end
    end
  end

  initial begin
    int i;
    int k;
    trtl_out_t fixed_hit;
    errors = 0;
    cycles = 0;
    results_seen = 0;
    hold_off = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    for (i = 0; i < 3; i++) tbl_n[i] = 0;
    pick_lfsr = 32'd1;
    ecmp_mode = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    fixed_hit = '0;
    fixed_hit.status = ST_OK;
    fixed_hit.route_dest = 32'hFFFF_FFFF;
    fixed_hit.route_gateway = 32'hFFFF_FFFF;
    fixed_hit.route_interface = 4'hF;
    fixed_hit.route_count = 6'd1;
    add_row(mk(CMD_LOOKUP, 32'h0, 32'h0, 32'h0, 4'h0, 5'd16, 6'd0), 1'b1, res(ST_NORTE, 6'd0));
    add_row(mk(CMD_REMOVE, 32'h0, 32'h0, 32'h0, 4'h0, 5'd0, 6'd0), 1'b1, res(ST_RANGE, 6'd0));
    add_row(mk(CMD_REMOVE, 32'h0, 32'h0, 32'h0, 4'h0, 5'd0, 6'd63), 1'b1, res(ST_RANGE, 6'd0));
    add_row(mk(trtl_cmd_e'(3'd7), 32'h1, 32'h1, 32'h1, 4'h1, 5'd1, 6'd1), 1'b1,
            res(ST_OK, 6'd0));
    add_row(mk(CMD_ADD_HST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 5'd31, 6'd63),
            1'b1, res(ST_OK, 6'd1));
    add_row(mk(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 4'h0, 5'd31, 6'd0), 1'b1, fixed_hit);
    add_row(mk(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 4'h0, 5'd15, 6'd0), 1'b1, fixed_hit);
    add_row(mk(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 4'h0, 5'd0, 6'd0), 1'b1,
            res(ST_NORTE, 6'd1));
    add_row(mk(CMD_ADD_NET, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_0001, 4'h2, 5'd0, 6'd0),
            1'b0, '0);
    add_row(mk(CMD_ADD_NET, 32'h0A01_0200, 32'hFFFF_FF00, 32'h0, 4'h3, 5'd0, 6'd0), 1'b0, '0);
    add_row(mk(CMD_ADD_EXT, 32'h0, 32'h0, 32'h0505_0505, 4'h4, 5'd0, 6'd0), 1'b0, '0);
    add_row(mk(CMD_ADD_EXT, 32'h0, 32'h0, 32'h0606_0606, 4'h5, 5'd0, 6'd0), 1'b0, '0);
    add_row(mk(CMD_LOOKUP, 32'h0A01_0203, 32'h0, 32'h0, 4'h0, 5'd16, 6'd0), 1'b0, '0);
    add_row(mk(CMD_LOOKUP, 32'h0A01_0203, 32'h0, 32'h0, 4'h0, 5'd3, 6'd0), 1'b0, '0);
    add_row(mk(CMD_LOOKUP, 32'h0B00_0000, 32'h0, 32'h0, 4'h0, 5'd16, 6'd0), 1'b0, '0);
    add_row(mk(CMD_LOOKUP, 32'h0B00_0000, 32'h0, 32'h0, 4'h0, 5'd5, 6'd0), 1'b0, '0);
    add_row(mk(CMD_REMOVE, 32'h0, 32'h0, 32'h0, 4'h0, 5'd0, 6'd1), 1'b0, '0);
    add_row(mk(CMD_REMOVE, 32'h0, 32'h0, 32'h0, 4'h0, 5'd0, 6'd4), 1'b0, '0);
    for (k = 0; k < 17; k++)
      add_row(mk(CMD_ADD_HST, 32'hC0A8_0000 | k, 32'h0, 32'(k), 4'(k), 5'd0, 6'd0), 1'b0, '0);

    foreach (rows[r]) begin
      if (rows[r].check_fixed) begin
        send_item(rows[r].item);
        route_q[route_q.size() - 1] = rows[r].fixed;
      end else begin
        send_item(rows[r].item);
      end
    end
    drain();

    // fill up with the receiver held off
    set_ecmp(1'b1);
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      for (k = 0; k < 30; k++) send_item(rand_item());
    join
    for (k = 0; k < 300; k++) send_item(rand_item());
    drain();
    set_ecmp(1'b0);
    for (k = 0; k < 300; k++) send_item(rand_item());
    drain();
    set_ecmp(1'b1);
    // several equal-cost routes to one prefix
    for (k = 0; k < 8; k++)
      send_item(mk(CMD_ADD_NET, 32'h0A00_0000, 32'hFF00_0000, $urandom, 4'($urandom_range(0, 3)),
                   5'd0, 6'd0));
    for (k = 0; k < 300; k++) send_item(rand_item());
    drain();

    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/trtl_pkg.sv
design/trtl_cell.sv
design/trtl_tier.sv
design/trtl_mod.sv
design/tiered_route_table_lookup.sv
verif/tb_top.sv
